// ===== design/dtstc_pkg.sv =====
// shared types and constants for the dense-to-sparse threshold coder
`default_nettype none
package dtstc_pkg;
  localparam int unsigned MaxDim = 65536;
  localparam int DimW = $clog2(MaxDim);
  localparam int ExtW = DimW + 1;

  localparam logic [1:0] KIND_COLUMN = 2'd0;
  localparam logic [1:0] KIND_ROW = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_ROWS = 2'd2;
  localparam logic [1:0] REG_COLS = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [DimW-1:0] column_index;
    logic [DimW-1:0] row_index;
    logic [ExtW-1:0] hit_count;
    logic last;
  } result_t;
endpackage
`default_nettype wire

// ===== design/dense_to_sparse_threshold_coder_unit.sv =====
// top level of the dense-to-sparse threshold coder
// Elements stream in row-major order on the input channel (in_valid, in_stall),
// one per cycle while in_stall is low. The pass test and position update happen
// as the element is accepted; up to three results (passing column, row summary,
// end marker) are placed in a four-entry result buffer and drained one per
// cycle while out_stall is low on the output channel (out_valid, out_stall);
// last marks the final result of an element. An element with several results
// occupies the output for one transfer each; with out_stall low the sustained
// rate is one element per cycle when at most one result per element is
// produced, otherwise set by the output channel. in_stall is raised when the
// buffer might not hold a new element's results.
// Configuration writes (cfg_valid, cfg_ready always high, cfg_index,
// cfg_data) are applied at once and take effect on the next element.
// Synchronous reset clears positions, hit count, format and threshold, sets rows
// and columns in use to one and empties the buffer. A receiver stall holds the
// head result; input is throttled once fewer than three buffer entries are free.
`default_nettype none
module dense_to_sparse_threshold_coder_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic [31:0] element_value,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [1:0] cfg_index,
  input wire logic [31:0] cfg_data,
  output logic out_valid,
  input wire logic out_stall,
  output logic [1:0] kind,
  output logic [dtstc_pkg::DimW-1:0] column_index,
  output logic [dtstc_pkg::DimW-1:0] row_index,
  output logic [dtstc_pkg::ExtW-1:0] hit_count,
  output logic last
);
  import dtstc_pkg::*;

  logic number_format;
  logic [31:0] threshold_bits;
  logic [ExtW-1:0] rows_in_use, cols_in_use;
  logic [DimW-1:0] column_position, row_position;
  logic [ExtW-1:0] row_hits;

  result_t buf_q [0:3];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] fill;

  logic accept, pop;
  logic vnan, tnan, tneg, pass;
  logic [30:0] vmag, tmag;
  logic [ExtW-1:0] cols, rows, hits_inc;
  logic row_end, mat_end;
  result_t r0, r1, r2;
  logic [1:0] n_res;

  assign cfg_ready = 1'b1;
  assign in_stall = fill > 3'd1;
  assign accept = in_valid && !in_stall;
  assign out_valid = fill != 3'd0;
  assign pop = out_valid && !out_stall;
  assign kind = buf_q[rd_ptr].kind;
  assign column_index = buf_q[rd_ptr].column_index;
  assign row_index = buf_q[rd_ptr].row_index;
  assign hit_count = buf_q[rd_ptr].hit_count;
  assign last = buf_q[rd_ptr].last;

  always_comb begin
    if (number_format) begin
      vmag = {16'd0, element_value[14:0]};
      tmag = {16'd0, threshold_bits[14:0]};
      vnan = element_value[14:0] > 15'h7C00;
      tnan = threshold_bits[14:0] > 15'h7C00;
      tneg = threshold_bits[15];
    end else begin
      vmag = element_value[30:0];
      tmag = threshold_bits[30:0];
      vnan = element_value[30:0] > 31'h7F800000;
      tnan = threshold_bits[30:0] > 31'h7F800000;
      tneg = threshold_bits[31];
    end
    pass = !vnan && !tnan && (tneg || tmag == 31'd0 || vmag >= tmag);
    cols = (cols_in_use == '0) ? ExtW'(1) :
      (cols_in_use > ExtW'(MaxDim)) ? ExtW'(MaxDim) : cols_in_use;
    rows = (rows_in_use == '0) ? ExtW'(1) :
      (rows_in_use > ExtW'(MaxDim)) ? ExtW'(MaxDim) : rows_in_use;
    row_end = ({1'b0, column_position} + ExtW'(1)) >= cols;
    mat_end = row_end && (({1'b0, row_position} + ExtW'(1)) >= rows);
    hits_inc = row_hits + ExtW'(pass);
    r0 = '0; r1 = '0; r2 = '0;
    n_res = 2'd0;
    // pack results in order into r0..r2
    if (pass) begin
      r0.kind = KIND_COLUMN;
      r0.column_index = column_position;
      n_res = 2'd1;
    end
    if (row_end && hits_inc != '0) begin
      if (n_res == 2'd0) begin
        r0.kind = KIND_ROW; r0.row_index = row_position; r0.hit_count = hits_inc;
      end else begin
        r1.kind = KIND_ROW; r1.row_index = row_position; r1.hit_count = hits_inc;
      end
      n_res = n_res + 2'd1;
    end
    if (mat_end) begin
      case (n_res)
        2'd0: r0.kind = KIND_END;
        2'd1: r1.kind = KIND_END;
        default: r2.kind = KIND_END;
      endcase
      n_res = n_res + 2'd1;
    end
    case (n_res)
      2'd1: r0.last = 1'b1;
      2'd2: r1.last = 1'b1;
      2'd3: r2.last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= 1'b0;
      threshold_bits <= '0;
      rows_in_use <= ExtW'(1);
      cols_in_use <= ExtW'(1);
      column_position <= '0;
      row_position <= '0;
      row_hits <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FORMAT: number_format <= cfg_data[0];
          REG_THRESHOLD: threshold_bits <= cfg_data;
          REG_ROWS: rows_in_use <= cfg_data[ExtW-1:0];
          REG_COLS: cols_in_use <= cfg_data[ExtW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (row_end) begin
          row_hits <= '0;
          column_position <= '0;
          row_position <= mat_end ? '0 : row_position + DimW'(1);
        end else begin
          row_hits <= hits_inc;
          column_position <= column_position + DimW'(1);
        end
        if (n_res != 2'd0) buf_q[wr_ptr] <= r0;
        if (n_res > 2'd1) buf_q[wr_ptr + 2'd1] <= r1;
        if (n_res > 2'd2) buf_q[wr_ptr + 2'd2] <= r2;
        wr_ptr <= wr_ptr + n_res;
      end
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire
